FILE: design/ddr_pkg.sv
// ----------------------------------------------------------------------------
// ddr_pkg
// Shared types and constants of the differential drive ramp core.
// ----------------------------------------------------------------------------
package ddr_pkg;

	// event kinds on the input channel
	typedef enum logic [1:0] {
		KIND_PRESS   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_TICK    = 2'd2
	} kind_t;

	// direction keys, also the bit positions of the direction flags
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	// register indexes of the configuration port
	localparam logic [1:0] REG_MAX_LEFT  = 2'd0;
	localparam logic [1:0] REG_MAX_RIGHT = 2'd1;
	localparam logic [1:0] REG_STOP      = 2'd2;

	localparam int unsigned CfgW   = 10;
	localparam int unsigned SpeedW = 11;
	localparam int unsigned AddrW  = 4;
	localparam int unsigned DataW  = 32;

	localparam logic [CfgW-1:0] MaxLeftRst  = 10'd100;
	localparam logic [CfgW-1:0] MaxRightRst = 10'd100;
	localparam logic [CfgW-1:0] StopRst     = 10'd0;

	// speed change per step
	localparam logic signed [SpeedW:0] StepSize = 12'sd10;

	typedef struct packed {
		logic [CfgW-1:0] max_left;
		logic [CfgW-1:0] max_right;
		logic [CfgW-1:0] stop;
	} cfg_t;

	typedef struct packed {
		logic                     has_result;
		logic [3:0]               flags;
		logic signed [SpeedW-1:0] left;
		logic signed [SpeedW-1:0] right;
		logic                     ramping;
	} step_t;

endpackage

FILE: design/ddr_cfg.sv
// ----------------------------------------------------------------------------
// ddr_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module ddr_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ddr_pkg::AddrW-1:0] paddr,
	input  logic [ddr_pkg::DataW-1:0] pwdata,
	output logic [ddr_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output ddr_pkg::cfg_t             cfg
);
	import ddr_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_left  <= MaxLeftRst;
			cfg_q.max_right <= MaxRightRst;
			cfg_q.stop      <= StopRst;
		end else if (wr_en) begin
			// writes outside the register list are dropped
			case (reg_idx)
				REG_MAX_LEFT:  cfg_q.max_left  <= pwdata[CfgW-1:0];
				REG_MAX_RIGHT: cfg_q.max_right <= pwdata[CfgW-1:0];
				REG_STOP:      cfg_q.stop      <= pwdata[CfgW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_MAX_LEFT:  prdata = {{(DataW-CfgW){1'b0}}, cfg_q.max_left};
			REG_MAX_RIGHT: prdata = {{(DataW-CfgW){1'b0}}, cfg_q.max_right};
			REG_STOP:      prdata = {{(DataW-CfgW){1'b0}}, cfg_q.stop};
			default:       prdata = '0;
		endcase
	end

endmodule

FILE: design/ddr_step.sv
// ----------------------------------------------------------------------------
// ddr_step
// One event: flag update, target selection and slew-limited speed step.
// ----------------------------------------------------------------------------
module ddr_step (
	input  logic                             valid,
	input  logic [1:0]                       kind,
	input  logic [1:0]                       key,
	input  logic                             auto_repeat,
	input  ddr_pkg::cfg_t                    cfg,
	input  logic [3:0]                       flags,
	input  logic signed [ddr_pkg::SpeedW-1:0] left_now,
	input  logic signed [ddr_pkg::SpeedW-1:0] right_now,
	input  logic                             ramping,
	output ddr_pkg::step_t                   step
);
	import ddr_pkg::*;

	logic [3:0]               key_bit;
	logic                     key_set;
	logic                     press_evt;
	logic                     release_evt;
	logic                     tick_evt;
	logic                     run;
	logic [3:0]               flags_new;
	logic signed [SpeedW-1:0] ml;
	logic signed [SpeedW-1:0] mr;
	logic signed [SpeedW-1:0] st;
	logic signed [SpeedW-1:0] tl;
	logic signed [SpeedW-1:0] tr;
	logic                     at_tgt;

	function automatic logic signed [SpeedW-1:0] move_toward(
		input logic signed [SpeedW-1:0] cur,
		input logic signed [SpeedW-1:0] tgt
	);
		logic signed [SpeedW:0] cur_x;
		logic signed [SpeedW:0] diff;
		logic signed [SpeedW:0] nxt;
		cur_x = {cur[SpeedW-1], cur};
		diff  = {tgt[SpeedW-1], tgt} - cur_x;
		// within one step of the target: land on it
		if (diff > StepSize) begin
			nxt = cur_x + StepSize;
		end else if (diff < -StepSize) begin
			nxt = cur_x - StepSize;
		end else begin
			nxt = {tgt[SpeedW-1], tgt};
		end
		return nxt[SpeedW-1:0];
	endfunction

	assign key_bit     = 4'b0001 << key;
	assign key_set     = |(flags & key_bit);
	assign press_evt   = (kind == KIND_PRESS) && !auto_repeat && !key_set;
	assign release_evt = (kind == KIND_RELEASE) && !auto_repeat && key_set;
	assign tick_evt    = (kind == KIND_TICK) && ramping;
	assign run         = press_evt || release_evt || tick_evt;

	always_comb begin
		flags_new = flags;
		if (press_evt) begin
			flags_new = flags | key_bit;
		end else if (release_evt) begin
			flags_new = flags & ~key_bit;
		end
	end

	assign ml = {1'b0, cfg.max_left};
	assign mr = {1'b0, cfg.max_right};
	assign st = {1'b0, cfg.stop};

	// up beats down, left beats right
	always_comb begin
		priority if (flags_new[DIR_UP]) begin
			priority if (flags_new[DIR_LEFT]) begin
				tl = st;
				tr = mr;
			end else if (flags_new[DIR_RIGHT]) begin
				tl = ml;
				tr = st;
			end else begin
				tl = ml;
				tr = mr;
			end
		end else if (flags_new[DIR_DOWN]) begin
			priority if (flags_new[DIR_LEFT]) begin
				tl = st;
				tr = -mr;
			end else if (flags_new[DIR_RIGHT]) begin
				tl = -ml;
				tr = st;
			end else begin
				tl = -ml;
				tr = -mr;
			end
		end else if (flags_new[DIR_LEFT]) begin
			tl = -ml;
			tr = mr;
		end else if (flags_new[DIR_RIGHT]) begin
			tl = ml;
			tr = -mr;
		end else begin
			tl = st;
			tr = st;
		end
	end

	assign at_tgt = (left_now == tl) && (right_now == tr);

	always_comb begin
		step.has_result = valid && run;
		step.flags      = flags_new;
		step.left       = left_now;
		step.right      = right_now;
		step.ramping    = ramping;
		if (run && !at_tgt) begin
			step.left  = move_toward(left_now, tl);
			step.right = move_toward(right_now, tr);
		end
		if (run) begin
			step.ramping = !at_tgt;
		end
	end

endmodule

FILE: design/differential_drive_ramp_core.sv
// ----------------------------------------------------------------------------
// differential_drive_ramp_core
// Slew-rate-limited differential drive: key events to wheel speed commands.
// ----------------------------------------------------------------------------
// Input channel (evt_valid/evt_ready) carries key presses, key releases and
// timer ticks. Output channel (cmd_valid/cmd_ready) carries one wheel speed
// command for each event that runs a ramp step; ignored events (auto-repeat,
// redundant keys, ticks while not ramping, unknown kinds) give no command.
// An event is registered into the input register on transfer; processing it
// updates the drive state and loads the output register, which drives
// cmd_valid. One event per cycle is taken while the output side keeps up;
// the output register lets a new event enter while the previous command
// waits. When the receiver stalls, an event that produces a command holds
// in the input register and evt_ready drops.
// Reset clears the direction flags, ramping flag and both speeds (to the
// stop level reset value) and restores the configuration registers.
// Configuration is written over the APB-style port while the block is idle: a user rule, unchecked.
// ----------------------------------------------------------------------------
module differential_drive_ramp_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ddr_pkg::AddrW-1:0]         paddr,
	input  logic [ddr_pkg::DataW-1:0]         pwdata,
	output logic [ddr_pkg::DataW-1:0]         prdata,
	output logic                              pready,
	input  logic                              evt_valid,
	output logic                              evt_ready,
	input  logic [1:0]                        kind,
	input  logic [1:0]                        key,
	input  logic                              auto_repeat,
	output logic                              cmd_valid,
	input  logic                              cmd_ready,
	output logic signed [ddr_pkg::SpeedW-1:0] left_speed,
	output logic signed [ddr_pkg::SpeedW-1:0] right_speed,
	output logic                              still_ramping
);
	import ddr_pkg::*;

	cfg_t                     cfg;
	step_t                    step;

	logic                     valid_s1;
	logic [1:0]               kind_s1;
	logic [1:0]               key_s1;
	logic                     rep_s1;

	logic [3:0]               flags_q;
	logic signed [SpeedW-1:0] left_q;
	logic signed [SpeedW-1:0] right_q;
	logic                     ramping_q;

	logic                     out_valid_q;
	logic signed [SpeedW-1:0] out_left_q;
	logic signed [SpeedW-1:0] out_right_q;
	logic                     out_ramp_q;

	logic                     out_free;
	logic                     fire;

	ddr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ddr_step u_step (
		.valid       (valid_s1),
		.kind        (kind_s1),
		.key         (key_s1),
		.auto_repeat (rep_s1),
		.cfg         (cfg),
		.flags       (flags_q),
		.left_now    (left_q),
		.right_now   (right_q),
		.ramping     (ramping_q),
		.step        (step)
	);

	assign out_free  = !out_valid_q || cmd_ready;
	// an event with no command never waits for the output side
	assign fire      = valid_s1 && (!step.has_result || out_free);
	assign evt_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid) begin
			kind_s1 <= kind;
			key_s1  <= key;
			rep_s1  <= auto_repeat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= '0;
			left_q    <= {1'b0, StopRst};
			right_q   <= {1'b0, StopRst};
			ramping_q <= 1'b0;
		end else if (fire) begin
			flags_q   <= step.flags;
			left_q    <= step.left;
			right_q   <= step.right;
			ramping_q <= step.ramping;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && step.has_result) begin
			out_valid_q <= 1'b1;
		end else if (cmd_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && step.has_result) begin
			out_left_q  <= step.left;
			out_right_q <= step.right;
			out_ramp_q  <= step.ramping;
		end
	end

	assign cmd_valid     = out_valid_q;
	assign left_speed    = out_left_q;
	assign right_speed   = out_right_q;
	assign still_ramping = out_ramp_q;

endmodule
